[sv/bpc_pkg.sv]
package bpc_pkg;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} event_t;

	typedef struct packed {
		logic        held;
		logic        long_fired;
		logic [31:0] press_start;
	} btn_rec_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 16'd30;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd700;

	localparam int unsigned IN_TDATA_W = 40;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam int unsigned OUT_DEPTH = 3;
	localparam int unsigned OUT_PTR_W = 2;

endpackage

[sv/bpc_ram.sv]
module bpc_ram #(
	parameter int unsigned WIDTH = 34,
	parameter int unsigned DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/bpc_out_fifo.sv]
module bpc_out_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  bpc_pkg::event_t              push_data,
	input  logic                         pop,
	output logic                         not_empty,
	output bpc_pkg::event_t              head_data,
	output logic [bpc_pkg::OUT_PTR_W-1:0] count
);

	bpc_pkg::event_t                 ent_q [bpc_pkg::OUT_DEPTH];
	logic [bpc_pkg::OUT_PTR_W-1:0]   wr_ptr_q;
	logic [bpc_pkg::OUT_PTR_W-1:0]   rd_ptr_q;
	logic [bpc_pkg::OUT_PTR_W-1:0]   cnt_q;
	logic                            do_pop;

	assign not_empty = (cnt_q != '0);
	assign head_data = ent_q[rd_ptr_q];
	assign count     = cnt_q;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bpc_pkg::OUT_PTR_W'(bpc_pkg::OUT_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bpc_pkg::OUT_PTR_W'(bpc_pkg::OUT_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/button_short_long_press_classifier_unit.sv]
// short/long press classifier for a bank of push buttons
// input stream s_*: one poll per transfer, tdata = button[1:0], pressed[2],
// now_ms[34:3], zero filled to 40 bits
// output stream m_*: one press event per poll, tdata = event_res[1:0]
// (0 none, 1 short, 2 long), zero filled to 8 bits, in poll order
// config channel cfg_*: index 0 debounce_ms, 1 long_press_ms, 16-bit data;
// cfg_ready is always high, other indexes are dropped
// per-button record (held, long fired, press start) lives in a ram with a
// registered read; the poll reads it at acceptance and the next cycle
// updates and writes it back, with a bypass for back-to-back polls of the
// same button
// an event reaches m_tvalid through the stage-1 registers, then the output queue
// throughput: one poll per cycle while m_tready stays high
// a three-entry output queue absorbs stalls; s_tready drops once the queue
// plus the poll in flight would overflow it, nothing is lost
// reset: all buttons read as released via per-entry valid bits, registers
// return to 30 and 700 ms, queue empties; no clearing pass is needed
module button_short_long_press_classifier_unit #(
	parameter int unsigned NUM_BUTTONS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bpc_pkg::IN_TDATA_W-1:0]      s_tdata,  // button, pressed, now_ms
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bpc_pkg::OUT_TDATA_W-1:0]     m_tdata,  // event_res
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int unsigned EW = AW + 2;
	localparam int unsigned RW = $bits(bpc_pkg::btn_rec_t);

	logic [bpc_pkg::CFG_DATA_W-1:0] debounce_q;
	logic [bpc_pkg::CFG_DATA_W-1:0] long_press_q;

	logic                 in_xfer;
	logic [EW-1:0]        btn_ext;
	logic [AW-1:0]        rd_addr;
	logic                 in_range;

	logic                 valid_s1;
	logic                 in_range_s1;
	logic [AW-1:0]        addr_s1;
	logic                 pressed_s1;
	logic [31:0]          now_s1;

	logic [NUM_BUTTONS-1:0] ent_valid_q;
	logic                 fwd_valid_q;
	logic [AW-1:0]        fwd_addr_q;
	bpc_pkg::btn_rec_t    fwd_rec_q;

	logic [RW-1:0]        ram_rdata;
	bpc_pkg::btn_rec_t    rec_cur;
	bpc_pkg::btn_rec_t    rec_nxt;
	bpc_pkg::event_t      ev;
	logic [31:0]          dur;
	logic                 wr_en;

	logic                 q_not_empty;
	bpc_pkg::event_t      q_head;
	logic [bpc_pkg::OUT_PTR_W-1:0] q_count;
	logic [bpc_pkg::OUT_PTR_W:0]   occupied;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bpc_pkg::DEBOUNCE_RST;
			long_press_q <= bpc_pkg::LONG_PRESS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bpc_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_data;
				bpc_pkg::REG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign occupied = {1'b0, q_count} + {{bpc_pkg::OUT_PTR_W{1'b0}}, valid_s1};
	assign s_tready = (occupied < (bpc_pkg::OUT_PTR_W + 1)'(bpc_pkg::OUT_DEPTH));
	assign in_xfer  = s_tvalid && s_tready;

	assign btn_ext  = EW'(s_tdata[1:0]);
	assign rd_addr  = btn_ext[AW-1:0];
	assign in_range = (btn_ext < EW'(NUM_BUTTONS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			ent_valid_q <= '0;
		end else begin
			valid_s1    <= in_xfer;
			fwd_valid_q <= wr_en;
			if (wr_en) begin
				ent_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			in_range_s1 <= in_range;
			addr_s1     <= rd_addr;
			pressed_s1  <= s_tdata[2];
			now_s1      <= s_tdata[34:3];
		end
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_rec_q  <= rec_nxt;
		end
	end

	bpc_ram #(
		.WIDTH(RW),
		.DEPTH(NUM_BUTTONS)
	) u_rec_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(rec_nxt),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign wr_en = valid_s1 && in_range_s1;

	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			rec_cur = fwd_rec_q;
		end else if (in_range_s1 && ent_valid_q[addr_s1]) begin
			rec_cur = bpc_pkg::btn_rec_t'(ram_rdata);
		end else begin
			rec_cur = '0;
		end
	end

	assign dur = now_s1 - rec_cur.press_start;

	always_comb begin
		rec_nxt = rec_cur;
		ev      = bpc_pkg::EV_NONE;
		if (pressed_s1) begin
			if (!rec_cur.held) begin
				rec_nxt.held        = 1'b1;
				rec_nxt.long_fired  = 1'b0;
				rec_nxt.press_start = now_s1;
			end else if (!rec_cur.long_fired && (dur >= {16'd0, long_press_q})) begin
				rec_nxt.long_fired = 1'b1;
				ev                 = bpc_pkg::EV_LONG;
			end
		end else if (rec_cur.held) begin
			rec_nxt = '0;
			if (!rec_cur.long_fired && (dur >= {16'd0, debounce_q})) begin
				ev = bpc_pkg::EV_SHORT;
			end
		end
		if (!in_range_s1) begin
			ev = bpc_pkg::EV_NONE;
		end
	end

	bpc_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1),
		.push_data(ev),
		.pop      (m_tready),
		.not_empty(q_not_empty),
		.head_data(q_head),
		.count    (q_count)
	);

	assign m_tvalid = q_not_empty;
	assign m_tdata  = bpc_pkg::OUT_TDATA_W'(q_head);

endmodule
